>>> sv/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types, widths, codes and the control program of the quadratic-probe
// key/value table.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int TABLE_SLOTS = 512;
  localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_W     = 10;
  localparam int STATUS_W    = 2;
  localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = COUNT_W'(384);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // One table slot
  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } qpht_slot_t;

  // Access to the slot store: one write and one read port
  typedef struct packed {
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    qpht_slot_t         wr_data;
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
  } qpht_mem_req_t;

  // Sequencer steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_CLEAR   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_READ    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PROBE   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ADVANCE = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RESOLVE = 3'd5;

  // Micro-operations
  localparam int UOP_W = 3;
  localparam logic [UOP_W-1:0] UOP_NOP     = 3'd0;
  localparam logic [UOP_W-1:0] UOP_CLEAR   = 3'd1;
  localparam logic [UOP_W-1:0] UOP_LOAD    = 3'd2;
  localparam logic [UOP_W-1:0] UOP_READ    = 3'd3;
  localparam logic [UOP_W-1:0] UOP_ADVANCE = 3'd4;
  localparam logic [UOP_W-1:0] UOP_RESOLVE = 3'd5;

  // Jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd0;
  localparam logic [COND_W-1:0] COND_REQ_BEAT   = 3'd1;
  localparam logic [COND_W-1:0] COND_HIT        = 3'd2;
  localparam logic [COND_W-1:0] COND_EXHAUST    = 3'd3;
  localparam logic [COND_W-1:0] COND_RSP_FREE   = 3'd4;
  localparam logic [COND_W-1:0] COND_CLEAR_DONE = 3'd5;

  // One control word: action, condition, target when true, target when false
  typedef struct packed {
    logic [UOP_W-1:0]  uop;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] jump_true;
    logic [STEP_W-1:0] jump_false;
  } qpht_ctrl_t;

  // Control program
  function automatic qpht_ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
    qpht_ctrl_t w;
    unique case (step)
      STEP_CLEAR:   w = '{UOP_CLEAR,   COND_CLEAR_DONE, STEP_IDLE,    STEP_CLEAR};
      STEP_IDLE:    w = '{UOP_LOAD,    COND_REQ_BEAT,   STEP_READ,    STEP_IDLE};
      STEP_READ:    w = '{UOP_READ,    COND_ALWAYS,     STEP_PROBE,   STEP_PROBE};
      STEP_PROBE:   w = '{UOP_NOP,     COND_HIT,        STEP_RESOLVE, STEP_ADVANCE};
      STEP_ADVANCE: w = '{UOP_ADVANCE, COND_EXHAUST,    STEP_RESOLVE, STEP_PROBE};
      STEP_RESOLVE: w = '{UOP_RESOLVE, COND_RSP_FREE,   STEP_IDLE,    STEP_RESOLVE};
      default:      w = '{UOP_NOP,     COND_ALWAYS,     STEP_IDLE,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/qpht_if.sv
// ----------------------------------------------------------------------------
// qpht interfaces
// Valid/ready channels for requests, responses and the limit register write.
// ----------------------------------------------------------------------------
interface qpht_req_if import qpht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [31:0]           key;
  logic [31:0]           key_hash;
  logic [31:0]           new_value;

  modport source (output valid, func, key, key_hash, new_value, input ready);
  modport sink   (input valid, func, key, key_hash, new_value, output ready);
endinterface

interface qpht_rsp_if import qpht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [31:0]         read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

interface qpht_cfg_if import qpht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> sv/qpht_store.sv
// ----------------------------------------------------------------------------
// qpht_store
// Slot memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qpht_store import qpht_pkg::*; (
  input  logic          clk,
  input  qpht_mem_req_t req,
  output qpht_slot_t    rd_data
);

  qpht_slot_t mem [TABLE_SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> sv/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed key/value table with quadratic probing, run by a small
// microcoded sequencer over one slot memory.
// ----------------------------------------------------------------------------
// Operation: a request beat loads the key and its hash, the slot at the hash
//   is read and then compared, and on each miss the position steps on by the
//   next square and the next slot is read and compared, until a slot hits or
//   every round has missed. One item is in work: a new request is taken only
//   after the last response is loaded into the response register.
// Reset: synchronous; a clearing pass over all TABLE_SLOTS (512) slots empties
//   them before the first request is taken. Limit register resets to 384.
module quadratic_probe_hash_table import qpht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qpht_cfg_if.sink   cfg,
  qpht_req_if.sink   req,
  qpht_rsp_if.source rsp
);

  logic [STEP_W-1:0]     step;
  logic [STEP_W-1:0]     step_next;
  qpht_ctrl_t            ctrl;
  logic                  cond_ok;

  logic [COUNT_W-1:0]    max_entries;
  logic [COUNT_W-1:0]    occupied_count;

  logic                  op_func;
  logic [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0] op_value;
  logic [SLOT_AW-1:0]    pos;
  logic [SLOT_AW-1:0]    round;
  logic [SLOT_AW-1:0]    sq;
  logic [SLOT_AW-1:0]    sq_next;
  logic [SLOT_AW-1:0]    pos_next;
  logic                  exhausted;

  qpht_mem_req_t         mem_req;
  qpht_slot_t            slot;
  logic                  slot_match;
  logic                  hit;
  logic                  last_round;
  logic                  rsp_free;
  logic                  can_fill;

  logic                  rsp_valid;
  logic [STATUS_W-1:0]   rsp_status;
  logic [31:0]           rsp_value;

  qpht_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (slot)
  );

  assign ctrl = ctrl_rom(step);

  // Probe arithmetic: next square by adding 2i+1, then step the position
  assign sq_next    = sq + {round[SLOT_AW-2:0], 1'b1};
  assign pos_next   = pos + sq_next;
  assign last_round = (round == SLOT_AW'(TABLE_SLOTS - 1));

  assign slot_match = slot.valid && (slot.key == op_key);
  assign hit        = !slot.valid || slot_match;
  assign rsp_free   = !rsp_valid || rsp.ready;
  assign can_fill   = (op_func == FUNC_INSERT) && (occupied_count < max_entries);

  // Jump condition select
  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:     cond_ok = 1'b1;
      COND_REQ_BEAT:   cond_ok = req.valid;
      COND_HIT:        cond_ok = hit;
      COND_EXHAUST:    cond_ok = last_round;
      COND_RSP_FREE:   cond_ok = rsp_free;
      COND_CLEAR_DONE: cond_ok = (pos == SLOT_AW'(TABLE_SLOTS - 1));
      default:         cond_ok = 1'b1;
    endcase
  end

  assign step_next = cond_ok ? ctrl.jump_true : ctrl.jump_false;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  // Memory port drive
  always_comb begin
    mem_req         = '0;
    mem_req.wr_addr = pos;
    mem_req.rd_addr = pos;
    mem_req.wr_data = '{1'b1, op_key, op_value};
    unique case (ctrl.uop)
      UOP_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = '0;
      end
      UOP_READ: begin
        mem_req.rd_en = 1'b1;
      end
      UOP_ADVANCE: begin
        mem_req.rd_en   = !last_round;
        mem_req.rd_addr = pos_next;
      end
      UOP_RESOLVE: begin
        mem_req.wr_en = rsp_free && !exhausted &&
                        (slot_match ? (op_func == FUNC_INSERT) : can_fill);
      end
      default: begin
        mem_req.wr_en = 1'b0;
      end
    endcase
  end

  // Probe state and captured request
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      unique case (ctrl.uop)
        UOP_CLEAR: begin
          pos <= pos + 1'b1;
        end
        UOP_LOAD: begin
          if (req.valid) begin
            pos <= req.key_hash[SLOT_AW-1:0];
          end
        end
        UOP_ADVANCE: begin
          pos <= pos_next;
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop == UOP_LOAD && req.valid) begin
      op_func   <= req.func;
      op_key    <= req.key[KEY_BITS-1:0];
      op_value  <= req.new_value[VALUE_BITS-1:0];
      round     <= '0;
      sq        <= '0;
      exhausted <= 1'b0;
    end else if (ctrl.uop == UOP_ADVANCE) begin
      round     <= round + 1'b1;
      sq        <= sq_next;
      exhausted <= last_round;
    end
  end

  // Limit register and occupancy
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= MAX_ENTRIES_RST;
      occupied_count <= '0;
    end else begin
      if (cfg.valid) begin
        max_entries <= cfg.data;
      end
      if (ctrl.uop == UOP_RESOLVE && rsp_free && !exhausted && !slot.valid && can_fill) begin
        occupied_count <= occupied_count + 1'b1;
      end
    end
  end

  // Response register: load on resolve, drop on beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.uop == UOP_RESOLVE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop == UOP_RESOLVE && rsp_free) begin
      rsp_value <= '0;
      if (exhausted || !slot.valid) begin
        if (!exhausted && can_fill) begin
          rsp_status <= ST_OK;
        end else begin
          rsp_status <= (op_func == FUNC_INSERT) ? ST_FULL : ST_MISSING;
        end
      end else if (op_func == FUNC_INSERT) begin
        rsp_status <= ST_UPDATED;
      end else begin
        rsp_status <= ST_OK;
        rsp_value  <= 32'(slot.value);
      end
    end
  end

  assign req.ready      = (step == STEP_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_value = rsp_value;

endmodule

>>> verif/quadratic_probe_hash_table_tb.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_tb
// Drives lookups, inserts and limit writes into the quadratic-probe table and
// checks every response beat against a shadow copy of the table kept here.
// A short stimulus table covers the obvious corners, then random phases run
// under several entry limits, and a last phase packs one probe sequence full
// so that inserts and lookups run out of probes.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_tb import qpht_pkg::*; ();

  localparam int PHASE_ITEMS     = 125;
  localparam int AIMED_ITEMS     = 45;
  localparam int HOLD_AFTER_BEAT = 120;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 1100;
  localparam int DRAIN_LIMIT     = 40000;
  localparam int WATCHDOG_TIME   = 60_000_000;
  localparam int LIMIT_MAX       = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         read_value;
  } reply_t;

  typedef struct {
    bit          set_limit;
    logic        func;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
    bit          typed;
    reply_t      want;
  } stim_row_t;

  typedef struct {
    logic [31:0] key;
    logic [31:0] hash;
  } key_ref_t;

  logic clk = 1'b0;
  logic rst;

  qpht_cfg_if cfg_ch ();
  qpht_req_if req_ch ();
  qpht_rsp_if rsp_ch ();

  quadratic_probe_hash_table dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table
  bit                    shadow_valid [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   shadow_key   [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] shadow_value [TABLE_SLOTS];
  int                    shadow_count = 0;
  logic [COUNT_W-1:0]    shadow_limit = MAX_ENTRIES_RST;

  reply_t             expected_replies [$];
  stim_row_t          directed_rows [$];
  key_ref_t           known_keys [$];
  key_ref_t           orbit_keys [$];
  logic [SLOT_AW-1:0] hot_buckets [8];

  int errors         = 0;
  int items_sent     = 0;
  int replies_seen   = 0;
  int limits_written = 0;
  int status_hist [4];

  always #5 clk = ~clk;

  // Walk the probe sequence over the shadow table and apply the item
  function automatic reply_t predict_reply(input logic func, input logic [31:0] key,
                                           input logic [31:0] hash,
                                           input logic [31:0] value);
    reply_t             r;
    logic [SLOT_AW-1:0] pos;
    bit                 done;
    r.status     = (func == FUNC_INSERT) ? ST_FULL : ST_MISSING;
    r.read_value = '0;
    pos          = hash[SLOT_AW-1:0];
    done         = 1'b0;
    for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
      pos = pos + SLOT_AW'(i * i);
      if (!shadow_valid[pos]) begin
        if (func == FUNC_INSERT && shadow_count < int'(shadow_limit)) begin
          shadow_valid[pos] = 1'b1;
          shadow_key[pos]   = key;
          shadow_value[pos] = value;
          shadow_count++;
          r.status = ST_OK;
        end
        done = 1'b1;
      end else if (shadow_key[pos] == key) begin
        if (func == FUNC_INSERT) begin
          shadow_value[pos] = value;
          r.status = ST_UPDATED;
        end else begin
          r.read_value = shadow_value[pos];
          r.status     = ST_OK;
        end
        done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t make_op(input logic func, input logic [31:0] key,
                                        input logic [31:0] hash, input logic [31:0] value);
    stim_row_t r;
    r.set_limit = 1'b0;
    r.func      = func;
    r.key       = key;
    r.hash      = hash;
    r.value     = value;
    r.typed     = 1'b0;
    r.want      = '0;
    return r;
  endfunction

  task automatic add_row(input logic func, input logic [31:0] key, input logic [31:0] hash,
                         input logic [31:0] value, input bit typed,
                         input logic [STATUS_W-1:0] status, input logic [31:0] rd);
    stim_row_t r;
    r                 = make_op(func, key, hash, value);
    r.typed           = typed;
    r.want.status     = status;
    r.want.read_value = rd;
    directed_rows.push_back(r);
  endtask

  task automatic add_limit(input logic [COUNT_W-1:0] lim);
    stim_row_t r;
    r           = make_op(FUNC_LOOKUP, '0, '0, 32'(lim));
    r.set_limit = 1'b1;
    directed_rows.push_back(r);
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Steer some hashes onto a few buckets so probe chains form
  function automatic logic [31:0] pick_hash();
    logic [31:0] h;
    h = $urandom();
    if ($urandom_range(0, 9) < 4) h[SLOT_AW-1:0] = hot_buckets[$urandom_range(0, 7)];
    return h;
  endfunction

  // New keys, updates, hits, misses and stale-hash probes
  function automatic stim_row_t random_row();
    int          pick;
    key_ref_t    entry;
    logic [31:0] v;
    stim_row_t   r;
    pick = $urandom_range(0, 99);
    v    = $urandom();
    if (pick < 35 || known_keys.size() == 0) begin
      entry.key  = rand_word();
      entry.hash = pick_hash();
      if (known_keys.size() > 400) void'(known_keys.pop_front());
      known_keys.push_back(entry);
      r = make_op(FUNC_INSERT, entry.key, entry.hash, v);
    end else begin
      entry = known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (pick < 55)      r = make_op(FUNC_INSERT, entry.key, entry.hash, v);
      else if (pick < 80) r = make_op(FUNC_LOOKUP, entry.key, entry.hash, v);
      else if (pick < 88) r = make_op(FUNC_LOOKUP, entry.key, $urandom(), v);
      else if (pick < 95) r = make_op(FUNC_LOOKUP, rand_word(), pick_hash(), v);
      else                r = make_op(FUNC_INSERT, entry.key, pick_hash(), v);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // Offer one request beat; keep valid high for a back-to-back follower
  task automatic send_item(input stim_row_t row);
    int     gap;
    reply_t want;
    gap = (items_sent % 64 < 16) ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= row.func;
    req_ch.key       <= row.key;
    req_ch.key_hash  <= row.hash;
    req_ch.new_value <= row.value;
    do @(posedge clk); while (!req_ch.ready);
    want = predict_reply(row.func, row.key, row.hash, row.value);
    if (row.typed) want = row.want;
    expected_replies.push_back(want);
    items_sent++;
  endtask

  // Drain outstanding work, then write the limit register
  task automatic set_limit(input logic [COUNT_W-1:0] lim);
    req_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_limit = lim;
    limits_written++;
  endtask

  // Compare each response beat with the oldest expectation
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        report_mismatch("response with nothing outstanding", 32'(rsp_ch.status), '0);
      end else begin
        want = expected_replies.pop_front();
        status_hist[want.status]++;
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.read_value !== want.read_value)
          report_mismatch("read_value", rsp_ch.read_value, want.read_value);
      end
    end
  end

  // Response side: random stalls, calm stretches, one long hold-off
  initial begin : drain_replies
    int gap;
    int beats;
    beats        = 0;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = (beats % 50 < 12) ? 0 : pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      beats++;
      // Hold off long enough for the request side to back up
      if (beats == HOLD_AFTER_BEAT) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_TIME);
    $display("timeout at %0t with %0d responses outstanding", $time, expected_replies.size());
    $display("quadratic_probe_hash_table_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int                 guard;
    int                 lim_calc;
    int                 pick;
    logic [SLOT_AW-1:0] start;
    logic [SLOT_AW-1:0] pos;
    bit                 seen [TABLE_SLOTS];
    logic [SLOT_AW-1:0] orbit [$];
    logic [31:0]        k;
    logic [31:0]        h;
    key_ref_t           entry;
    stim_row_t          row;

    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_LOOKUP;
    req_ch.key       = '0;
    req_ch.key_hash  = '0;
    req_ch.new_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    rst              = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: func, key, hash, value, typed, status, read_value
    add_row(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_MISSING, 0);
    add_row(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK, 0);
    add_row(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,
            32'hFFFF_FFFF);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK, 0);
    add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK, 0);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, ST_OK, 0);
    add_row(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, ST_UPDATED, 0);
    add_row(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,
            32'h5A5A_5A5A);
    add_row(FUNC_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISSING, 0);
    add_row(FUNC_INSERT, 32'hA5A5_A5A5, 32'h0000_0200, 32'hC3C3_C3C3, 1'b0, ST_OK, 0);
    add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0201, 32'h0000_0000, 1'b1, ST_OK, 0);
    add_limit(COUNT_W'(0));
    add_row(FUNC_INSERT, 32'h0000_0011, 32'h0000_0007, 32'h0000_0077, 1'b1, ST_FULL, 0);
    add_row(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 1'b1, ST_UPDATED, 0);
    add_row(FUNC_LOOKUP, 32'h0000_0011, 32'h0000_0007, 32'h0000_0000, 1'b1, ST_MISSING, 0);
    add_row(FUNC_LOOKUP, 32'hA5A5_A5A5, 32'hFFFF_FE00, 32'h0000_0000, 1'b1, ST_OK,
            32'hC3C3_C3C3);
    add_limit(COUNT_W'(LIMIT_MAX));
    add_row(FUNC_INSERT, 32'h0000_0011, 32'h0000_0007, 32'h0000_0077, 1'b1, ST_OK, 0);
    add_limit(COUNT_W'(5));
    add_row(FUNC_INSERT, 32'h0000_0022, 32'h0000_0009, 32'h0000_0022, 1'b1, ST_FULL, 0);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, ST_UPDATED, 0);
    add_limit(COUNT_W'(6));
    add_row(FUNC_INSERT, 32'h0000_0022, 32'h0000_0009, 32'h0000_0022, 1'b1, ST_OK, 0);
    add_row(FUNC_LOOKUP, 32'h0000_0022, 32'h0000_0009, 32'h0000_0000, 1'b0, ST_OK, 0);
    add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b1, ST_OK,
            32'hFFFF_FFFF);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].set_limit) set_limit(directed_rows[n].value[COUNT_W-1:0]);
      else send_item(directed_rows[n]);
    end

    // Random phases under a full-table, a one-entry, a near and the reset limit
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_limit(COUNT_W'(TABLE_SLOTS));
        1: set_limit(COUNT_W'(1));
        2: begin
          lim_calc = shadow_count + $urandom_range(20, 80);
          if (lim_calc > LIMIT_MAX) lim_calc = LIMIT_MAX;
          set_limit(COUNT_W'(lim_calc));
        end
        default: set_limit(MAX_ENTRIES_RST);
      endcase
      foreach (hot_buckets[b]) hot_buckets[b] = SLOT_AW'($urandom_range(0, TABLE_SLOTS - 1));
      repeat (PHASE_ITEMS) send_item(random_row());
    end

    // Fill every slot on one probe sequence so the walk runs out of rounds
    set_limit(COUNT_W'(LIMIT_MAX));
    start = SLOT_AW'($urandom_range(0, TABLE_SLOTS - 1));
    pos   = start;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      pos = pos + SLOT_AW'(i * i);
      if (!seen[pos]) begin
        seen[pos] = 1'b1;
        orbit.push_back(pos);
      end
    end
    foreach (orbit[n]) begin
      if (!shadow_valid[orbit[n]]) begin
        k = $urandom();
        h = $urandom();
        h[SLOT_AW-1:0] = orbit[n];
        entry.key  = k;
        entry.hash = h;
        orbit_keys.push_back(entry);
        send_item(make_op(FUNC_INSERT, k, h, $urandom()));
      end
    end

    // Aim new keys, misses and updates at the packed sequence, mixed with noise
    repeat (AIMED_ITEMS) begin
      pick = $urandom_range(0, 5);
      h    = $urandom();
      h[SLOT_AW-1:0] = start;
      if (pick == 0) begin
        row = make_op(FUNC_INSERT, $urandom(), h, $urandom());
      end else if (pick == 1) begin
        row = make_op(FUNC_LOOKUP, $urandom(), h, $urandom());
      end else if (pick == 2 && orbit_keys.size() != 0) begin
        entry = orbit_keys[$urandom_range(0, orbit_keys.size() - 1)];
        row = make_op(($urandom_range(0, 1) != 0) ? FUNC_INSERT : FUNC_LOOKUP,
                      entry.key, h, $urandom());
      end else begin
        row = random_row();
      end
      send_item(row);
    end
    req_ch.valid <= 1'b0;

    // Wait for the last responses, then watch for strays
    guard = 0;
    while (expected_replies.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("responses never arrived", expected_replies.size(), 0);

    $display("covered %0d requests under %0d limit settings, %0d slots held at the end",
             items_sent, limits_written, shadow_count);
    $display("responses: %0d found or added, %0d updated, %0d missing, %0d full",
             status_hist[ST_OK], status_hist[ST_UPDATED], status_hist[ST_MISSING],
             status_hist[ST_FULL]);
    if (errors == 0) begin
      $display("quadratic_probe_hash_table_tb OK");
    end else begin
      $display("quadratic_probe_hash_table_tb NOT OK");
    end
    $finish;
  end

endmodule
